FILE: hdl/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// Shared widths, codes and controller/datapath handshake types for the
// exact-match forwarding table.
// ----------------------------------------------------------------------------
package fte_pkg;

   // payload field widths
   localparam int ADDR_W    = 16;
   localparam int NODE_W    = 8;
   localparam int CNT_OUT_W = 5;

   // default number of table entries
   localparam int TABLE_DEPTH_DEFAULT = 16;

   // request action codes
   localparam logic ACT_MAP    = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;   // latch the request item, reset the scan index
      logic rd;     // read both stores at the scan index
      logic cmp;    // evaluate the read entry against the address
      logic step;   // advance the scan index
      logic write;  // write the entry, bump the count on an append
      logic emit;   // load the result register
   } fte_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic in_map;    // request at the port is a map
      logic is_map;    // latched item is a map
      logic full;      // every entry is filled
      logic empty;     // no entry is filled
      logic match;     // read entry holds the item's address
      logic last;      // scan index sits on the last filled entry
      logic out_free;  // result register can take a new item
   } fte_stat_type;

endpackage

FILE: hdl/fte_if.sv
// ----------------------------------------------------------------------------
// fte_if
// Valid/ready channels of the forwarding table: request, response and the
// default-node register write channel.
// ----------------------------------------------------------------------------
interface fte_req_if import fte_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] address;
   logic [NODE_W-1:0] node;

   modport source (output valid, action, address, node, input ready);
   modport sink   (input valid, action, address, node, output ready);
endinterface

interface fte_rsp_if import fte_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [NODE_W-1:0]    found_node;
   logic                 hit;
   logic                 overflow;
   logic [CNT_OUT_W-1:0] entry_count;

   modport source (output valid, found_node, hit, overflow, entry_count, input ready);
   modport sink   (input valid, found_node, hit, overflow, entry_count, output ready);
endinterface

interface fte_csr_if import fte_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/forwarding_table_exact_match_unit.sv
// ----------------------------------------------------------------------------
// forwarding_table_exact_match_unit
// Exact-match table of destination address to next-hop node, with a
// default node returned on a lookup miss.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake     Payload
//  req_ch    in    valid/ready   action, address, node
//  rsp_ch    out   valid/ready   found_node, hit, overflow, entry_count
//  csr_ch    in    valid/ready   data (default node, always ready)
//
//  One item at a time. After acceptance an item passes a read state and a
//  compare state for each entry compared (at most the fill count), then a
//  write state on a map that writes, before the result register. Each
//  compare needs a registered read of the stores followed by the compare.
//  Reset (synchronous) empties the table and clears the default node.
//  A stalled response holds in the result register; the next item is taken
//  meanwhile and waits for that register before it completes.
// ----------------------------------------------------------------------------
module forwarding_table_exact_match_unit import fte_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   fte_req_if.sink   req_ch,
   fte_rsp_if.source rsp_ch,
   fte_csr_if.sink   csr_ch
);

   fte_cmd_type  cmd;
   fte_stat_type stat;

   assign csr_ch.ready = 1'b1;

   fte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fte_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_ch.action),
      .req_address     (req_ch.address),
      .req_node        (req_ch.node),
      .csr_valid       (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_found_node  (rsp_ch.found_node),
      .rsp_hit         (rsp_ch.hit),
      .rsp_overflow    (rsp_ch.overflow),
      .rsp_entry_count (rsp_ch.entry_count)
   );

endmodule

FILE: hdl/fte_ctrl.sv
// ----------------------------------------------------------------------------
// fte_ctrl
// Sequencer of the forwarding table: accepts an item, walks the filled
// entries one compare at a time, writes on a map that is not refused and hands off the result.
// ----------------------------------------------------------------------------
module fte_ctrl import fte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  fte_stat_type stat,
   output fte_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_CMP   = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.in_map && stat.full) begin
                  state_in = ST_DONE;
               end else if (stat.empty) begin
                  state_in = stat.in_map ? ST_WRITE : ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
            if (stat.match || stat.last) begin
               state_in = stat.is_map ? ST_WRITE : ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/fte_dp.sv
// ----------------------------------------------------------------------------
// fte_dp
// Datapath of the forwarding table: address and node stores, entry count,
// scan index, compare, default-node register and the result register.
// ----------------------------------------------------------------------------
module fte_dp import fte_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fte_cmd_type          cmd,
   output fte_stat_type         stat,
   input  logic                 req_action,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [NODE_W-1:0]    req_node,
   input  logic                 csr_valid,
   input  logic [NODE_W-1:0]    csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [NODE_W-1:0]    rsp_found_node,
   output logic                 rsp_hit,
   output logic                 rsp_overflow,
   output logic [CNT_OUT_W-1:0] rsp_entry_count
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W = CNT_W + CNT_OUT_W;

   // stores, filled in order of insertion
   logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
   logic [NODE_W-1:0] node_mem [TABLE_DEPTH];

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [NODE_W-1:0] default_node_ff;
   logic              rsp_valid_ff;

   logic              act_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [NODE_W-1:0] node_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              hit_ff;
   logic              ovf_ff;
   logic [NODE_W-1:0] found_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [NODE_W-1:0] rd_node_ff;

   logic [NODE_W-1:0]    rsp_found_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_overflow_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff;

   logic [IDX_W-1:0] wr_idx;
   logic [EXT_W-1:0] count_ext;
   logic             full;

   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign wr_idx    = hit_ff ? idx_ff : count_ff[IDX_W-1:0];
   assign count_ext = EXT_W'(count_ff);

   // status toward the controller
   always_comb begin
      stat.in_map   = (req_action == ACT_MAP);
      stat.is_map   = (act_ff == ACT_MAP);
      stat.full     = full;
      stat.empty    = (count_ff == '0);
      stat.match    = (rd_addr_ff == addr_ff);
      stat.last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   // grow the count on an append
   assign count_in = (cmd.write && !hit_ff) ? count_ff + CNT_W'(1) : count_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         default_node_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_valid) begin
            default_node_ff <= csr_data;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item, scan index and partial result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         addr_ff  <= req_address;
         node_ff  <= req_node;
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
         ovf_ff   <= (req_action == ACT_MAP) && full;
         found_ff <= (req_action == ACT_LOOKUP) ? default_node_ff : '0;
      end else begin
         if (cmd.step) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.cmp && stat.match) begin
            hit_ff <= 1'b1;
            if (act_ff == ACT_LOOKUP) begin
               found_ff <= rd_node_ff;
            end
         end
      end
   end

   // store access: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         addr_mem[wr_idx] <= addr_ff;
      end
      if (cmd.rd) begin
         rd_addr_ff <= addr_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         node_mem[wr_idx] <= node_ff;
      end
      if (cmd.rd) begin
         rd_node_ff <= node_mem[idx_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff    <= found_ff;
         rsp_hit_ff      <= hit_ff;
         rsp_overflow_ff <= ovf_ff;
         rsp_count_ff    <= count_ext[CNT_OUT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_node  = rsp_found_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: hdl/fte_checker.sv
// ----------------------------------------------------------------------------
// fte_checker
// Port-level checks of the forwarding table, bound to the top level.
// ----------------------------------------------------------------------------
module fte_checker import fte_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [NODE_W-1:0]    rsp_found_node,
   input logic                 rsp_hit,
   input logic                 rsp_overflow,
   input logic [CNT_OUT_W-1:0] rsp_entry_count
);

   // hold a stalled response and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_node)
         && $stable(rsp_hit) && $stable(rsp_overflow) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // drop ready after taking an item
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // a refused map reports no hit and no node
   a_ovf_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_hit && (rsp_found_node == '0))
      else $error("overflow response carries hit or node");

   // a refused map sees a full table
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_entry_count == CNT_OUT_W'(TABLE_DEPTH))
      else $error("overflow with a table that is not full");

endmodule

bind forwarding_table_exact_match_unit fte_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_fte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_found_node  (rsp_ch.found_node),
   .rsp_hit         (rsp_ch.hit),
   .rsp_overflow    (rsp_ch.overflow),
   .rsp_entry_count (rsp_ch.entry_count)
);

FILE: dv/tb_forwarding_table_exact_match_unit.sv
// ----------------------------------------------------------------------------
// tb_forwarding_table_exact_match_unit
// Self-checking bench for the exact-match forwarding table. A directed table
// of map and lookup requests covers the empty table, the address and node
// extremes, node 0 and overwrites. Random traffic then fills the table,
// drives it into overflow and keeps scanning it. Each response is checked
// field by field against a local model of the table. Both channels idle at
// random, and the default node is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_forwarding_table_exact_match_unit import fte_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TBL_DEPTH     = TABLE_DEPTH_DEFAULT;
   localparam int ITEMS_PER_RUN = 450;
   localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 8;
   localparam int RUN_LIMIT     = 600000;
   localparam int PRINT_CAP     = 40;

   typedef struct packed {
      logic [NODE_W-1:0]    found;
      logic                 hit;
      logic                 ovf;
      logic [CNT_OUT_W-1:0] cnt;
   } route_result_type;

   typedef struct {
      logic              act;
      logic [ADDR_W-1:0] addr;
      logic [NODE_W-1:0] nd;
      bit                typed;
      route_result_type  want;
   } route_row_type;

   logic clock = 1'b0;
   logic reset;

   fte_req_if req_ch();
   fte_rsp_if rsp_ch();
   fte_csr_if csr_ch();

   forwarding_table_exact_match_unit #(.TABLE_DEPTH(TBL_DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // table model
   logic [ADDR_W-1:0] addr_tbl [TBL_DEPTH];
   logic [NODE_W-1:0] node_tbl [TBL_DEPTH];
   int                fill_cnt  = 0;
   logic [NODE_W-1:0] dflt_node = '0;

   route_result_type pending_routes [$];

   int errors         = 0;
   int cycles         = 0;
   int send_idle_pct  = 20;
   int recv_idle_pct  = 87;
   int n_lookup_hit   = 0;
   int n_lookup_miss  = 0;
   int n_append       = 0;
   int n_overwrite    = 0;
   int n_refused      = 0;
   int n_pauses       = 0;

   // directed requests; typed rows carry an expectation read off by hand
   route_row_type route_rows [16] = '{
      '{ACT_LOOKUP, 16'h0000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_LOOKUP, 16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_MAP,    16'h0000, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 5'd1}},
      '{ACT_MAP,    16'hFFFF, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 5'd2}},
      '{ACT_LOOKUP, 16'h0000, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, 5'd2}},
      '{ACT_LOOKUP, 16'hFFFF, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 5'd2}},
      '{ACT_MAP,    16'h0000, 8'h5A, 1'b1, '{8'h00, 1'b1, 1'b0, 5'd2}},
      '{ACT_LOOKUP, 16'h0000, 8'hA5, 1'b1, '{8'h5A, 1'b1, 1'b0, 5'd2}},
      '{ACT_LOOKUP, 16'h8000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 5'd2}},
      '{ACT_MAP,    16'hAAAA, 8'h55, 1'b0, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_MAP,    16'h5555, 8'hAA, 1'b0, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_LOOKUP, 16'h5555, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_LOOKUP, 16'hAAAB, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_MAP,    16'h0001, 8'h80, 1'b0, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_MAP,    16'h5555, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0, 5'd0}},
      '{ACT_LOOKUP, 16'h0001, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 5'd0}}
   };

   always #5 clock = ~clock;

   // count cycles and stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, pending_routes.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < PRINT_CAP)
         $display("MISMATCH @%0t %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   // apply one request to the table model and return its response
   function automatic route_result_type route_predict(input logic act,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic [NODE_W-1:0] nd);
      route_result_type r;
      int               slot;
      r    = '0;
      slot = -1;
      for (int i = 0; i < fill_cnt; i++)
         if (slot < 0 && addr_tbl[i] == addr)
            slot = i;
      if (act == ACT_MAP) begin
         if (fill_cnt >= TBL_DEPTH) begin
            r.ovf = 1'b1;
         end else if (slot >= 0) begin
            node_tbl[slot] = nd;
            r.hit          = 1'b1;
         end else begin
            addr_tbl[fill_cnt] = addr;
            node_tbl[fill_cnt] = nd;
            fill_cnt++;
         end
      end else begin
         if (slot >= 0) begin
            r.found = node_tbl[slot];
            r.hit   = 1'b1;
         end else begin
            r.found = dflt_node;
         end
      end
      r.cnt = fill_cnt[CNT_OUT_W-1:0];
      return r;
   endfunction

   // offer one request, hold it until taken, then queue its response
   task automatic send_route_req(input logic act, input logic [ADDR_W-1:0] addr,
                                 input logic [NODE_W-1:0] nd, input bit typed,
                                 input route_result_type typed_want);
      route_result_type model;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.address <= addr;
      req_ch.node    <= nd;
      do @(posedge clock); while (!req_ch.ready);
      model = route_predict(act, addr, nd);
      if (typed && model !== typed_want)
         report_mismatch("table model vs directed row", int'(model), int'(typed_want));
      pending_routes.push_back(typed ? typed_want : model);
      if (act == ACT_LOOKUP) begin
         if (model.hit) n_lookup_hit++;
         else n_lookup_miss++;
      end else if (model.ovf) begin
         n_refused++;
      end else if (model.hit) begin
         n_overwrite++;
      end else begin
         n_append++;
      end
   endtask

   // drop valid and hold until every queued response has arrived
   task automatic wait_results();
      req_ch.valid <= 1'b0;
      while (pending_routes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_default(input logic [NODE_W-1:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      dflt_node     = value;
      csr_ch.valid <= 1'b0;
   endtask

   // random request, mostly aimed at stored addresses
   task automatic send_random_req();
      int                pick;
      int                idx;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      addr = ADDR_W'($urandom_range(16'hFFFF));
      if (fill_cnt > 0) begin
         idx = $urandom_range(fill_cnt - 1);
         if (pick < 45 || (pick >= 60 && pick < 75))
            addr = addr_tbl[idx];
         else if (pick < 52)
            addr = addr_tbl[idx] ^ (16'h1 << $urandom_range(ADDR_W - 1));
      end
      send_route_req((pick < 60) ? ACT_LOOKUP : ACT_MAP, addr,
                     NODE_W'($urandom_range(8'hFF)), 1'b0, '0);
   endtask

   // hold the response channel ready at the current idle rate
   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

   // check each response against the oldest expectation
   always @(posedge clock) begin
      route_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_routes.size() == 0) begin
            report_mismatch("response with none expected",
                            int'({rsp_ch.found_node, rsp_ch.hit, rsp_ch.overflow,
                                  rsp_ch.entry_count}), 0);
         end else begin
            want = pending_routes.pop_front();
            if (rsp_ch.found_node !== want.found)
               report_mismatch("found_node", int'(rsp_ch.found_node), int'(want.found));
            if (rsp_ch.hit !== want.hit)
               report_mismatch("hit", int'(rsp_ch.hit), int'(want.hit));
            if (rsp_ch.overflow !== want.ovf)
               report_mismatch("overflow", int'(rsp_ch.overflow), int'(want.ovf));
            if (rsp_ch.entry_count !== want.cnt)
               report_mismatch("entry_count", int'(rsp_ch.entry_count), int'(want.cnt));
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.action  <= ACT_MAP;
      req_ch.address <= '0;
      req_ch.node    <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table, default node at zero
      write_default(8'h00);
      foreach (route_rows[i])
         send_route_req(route_rows[i].act, route_rows[i].addr, route_rows[i].nd,
                        route_rows[i].typed, route_rows[i].want);
      wait_results();

      // random phases: receiver-heavy idling, sender-heavy idling, none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 87 : 0;
         recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 20 : 0;
         write_default((phase == 0) ? 8'hFF :
                       (phase == 1) ? 8'($urandom_range(1, 254)) : 8'h00);
         for (int n = 0; n < ITEMS_PER_RUN; n++) begin
            send_random_req();
            if ($urandom_range(63) == 0) begin
               wait_results();
               n_pauses++;
            end
         end
         wait_results();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d lookups (%0d hit, %0d miss) and %0d maps",
               n_lookup_hit + n_lookup_miss, n_lookup_hit, n_lookup_miss,
               n_append + n_overwrite + n_refused);
      $display("Maps: %0d new, %0d rewrite, %0d full; table ended with %0d entries",
               n_append, n_overwrite, n_refused, fill_cnt);
      $display("4 default-node writes, %0d drain pauses, %0d errors", n_pauses, errors);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
